// File: hdl/shs_pkg.sv
// Shared types, widths, defaults and fixed-point helpers for the sparse Hessian substitution block.
`default_nettype none

package shs_pkg;

  localparam int INDEX_W  = 10;
  localparam int COLOR_W  = 4;
  localparam int SAMPLE_W = 32;
  localparam int INV_W    = 32;
  localparam int VALUE_W  = 48;
  localparam int PROD_W   = SAMPLE_W + INV_W;
  localparam int FRAC_W   = 16;

  localparam int MAX_VARS_DEF   = 1024;
  localparam int MAX_COLORS_DEF = 16;

  localparam logic [INV_W-1:0] STEP_RECIP_RESET = INV_W'(65536);

  typedef logic        [INDEX_W-1:0]  index_t;
  typedef logic        [COLOR_W-1:0]  color_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [INV_W-1:0]    inv_t;
  typedef logic signed [VALUE_W-1:0]  value_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [VALUE_W:0]    wide_value_t;

  localparam value_t VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  // Clamp a sum or difference of two Q32.16 words back to 48 bits.
  function automatic value_t sat_value(input wide_value_t v);
    value_t r;
    if (v[VALUE_W] != v[VALUE_W-1]) begin
      r = v[VALUE_W] ? VALUE_MIN : VALUE_MAX;
    end else begin
      r = v[VALUE_W-1:0];
    end
    return r;
  endfunction

  // Q32.32 product to Q32.16: round half up, then clamp to 48 bits.
  function automatic value_t round_product(input prod_t p);
    prod_t  t;
    value_t r;
    t = p + PROD_W'(1 << (FRAC_W - 1));
    if (t[PROD_W-1:VALUE_W+FRAC_W-1] != {(PROD_W-VALUE_W-FRAC_W+1){t[PROD_W-1]}}) begin
      r = t[PROD_W-1] ? VALUE_MIN : VALUE_MAX;
    end else begin
      r = t[VALUE_W+FRAC_W-1:FRAC_W];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/shs_if.sv
// Valid/ready channel interfaces for nonzero requests and Hessian entry results.
`default_nettype none

interface shs_item_if;
  import shs_pkg::*;

  logic    valid;
  logic    ready;
  index_t  row_index;
  index_t  col_index;
  color_t  row_color;
  color_t  col_color;
  sample_t y_sample;

  modport source(output valid, output row_index, output col_index, output row_color,
                 output col_color, output y_sample, input ready);
  modport sink(input valid, input row_index, input col_index, input row_color,
               input col_color, input y_sample, output ready);
endinterface

interface shs_result_if;
  import shs_pkg::*;

  logic   valid;
  logic   ready;
  index_t out_row;
  index_t out_col;
  value_t entry_value;
  logic   last;

  modport source(output valid, output out_row, output out_col, output entry_value,
                 output last, input ready);
  modport sink(input valid, input out_row, input out_col, input entry_value,
               input last, output ready);
endinterface

`default_nettype wire

// File: hdl/sparse_hessian_substitution.sv
// Sparse Hessian recovery by triangular substitution over a colored substitution store.
//
// Usage: each request on the item channel is one lower-triangle nonzero (row, column, the
// colors of both variables and the Q16.16 gradient difference), fed in descending row order.
// The block computes z = y_sample*step_recip - store[col_color][row] and adds z into
// store[row_color][col]. Each request yields the entry (row, col, z) on the result channel;
// an off-diagonal request is followed by its mirror (col, row, z). The final result of a
// request carries last = 1. step_recip is written through step_recip_we/step_recip_wdata;
// the user must do so only while the block is idle, which the block does not enforce; it
// resets to 1.0. A request passes stage 1 (read), stage 2 (rounding), stage 3 (substitution)
// and the result register before its result is presented. Throughput: one request per cycle
// for diagonal entries while result.ready is high; an off-diagonal request holds the single
// result register for both of its beats, so the next request waits for the mirror beat. The
// store is one memory with two read ports and one write port; a request reads both words when
// it is accepted and its update is written back the cycle after it leaves the substitution
// stage. Updates still in flight are forwarded to every later request, so dependent requests
// can follow back to back. Reset: the store is cleared by a pass that writes one word per
// cycle over all MAX_COLORS*MAX_VARS words (16384 with the defaults); item.ready stays low
// until it finishes. Stalls: when result.ready is low the result register holds, and the
// stages ahead of it keep taking requests until each of them holds one; then item.ready falls.
`default_nettype none

module sparse_hessian_substitution #(
  parameter int MAX_VARS   = shs_pkg::MAX_VARS_DEF,
  parameter int MAX_COLORS = shs_pkg::MAX_COLORS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step_recip_we,
  input  logic [shs_pkg::INV_W-1:0] step_recip_wdata,
  shs_item_if.sink            item,
  shs_result_if.source        result
);
  import shs_pkg::*;

  localparam int DEPTH  = MAX_COLORS * MAX_VARS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef logic [ADDR_W-1:0] addr_t;

  // Flat store address of (color, variable).
  function automatic addr_t store_addr(input color_t c, input index_t v);
    return ADDR_W'(32'(c) * 32'(MAX_VARS) + 32'(v));
  endfunction

  // Words outside the store read as zero and drop their writes.
  function automatic logic in_store(input color_t c, input index_t v);
    return (32'(c) < 32'(MAX_COLORS)) && (32'(v) < 32'(MAX_VARS));
  endfunction

  // Configuration register.
  inv_t step_recip;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_recip <= STEP_RECIP_RESET;
    end else if (step_recip_we) begin
      step_recip <= step_recip_wdata;
    end
  end

  // Store clearing pass after reset.
  logic  clearing;
  addr_t clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Write-back register: the update of the request that left the substitution stage.
  logic   wb_we;
  addr_t  wb_addr;
  value_t wb_data;

  // Pipeline control.
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic en1, en2, en3;
  logic accept, load2, load3, load4;
  logic s4_done, out_fire;
  logic s4_phase, s4_diag;

  assign out_fire = result.valid && result.ready;
  assign s4_done  = out_fire && (s4_diag || s4_phase);
  assign en3      = !s4_valid || s4_done;
  assign en2      = !s3_valid || en3;
  assign en1      = !s2_valid || en2;
  assign item.ready = !clearing && (!s1_valid || en1);
  assign accept   = item.valid && item.ready;
  assign load2    = s1_valid && en1;
  assign load3    = s2_valid && en2;
  assign load4    = s3_valid && en3;

  // Request addresses.
  addr_t a_addr_in, b_addr_in;
  logic  a_ok_in, b_ok_in;

  assign a_addr_in = store_addr(item.col_color, item.row_index);
  assign a_ok_in   = in_store(item.col_color, item.row_index);
  assign b_addr_in = store_addr(item.row_color, item.col_index);
  assign b_ok_in   = in_store(item.row_color, item.col_index);

  // Store memory: two registered reads on acceptance, one write port.
  value_t store_mem [DEPTH];
  value_t rd_a, rd_b;
  logic   mem_we;
  addr_t  mem_waddr;
  value_t mem_wdata;

  assign mem_we    = clearing || wb_we;
  assign mem_waddr = clearing ? clr_addr : wb_addr;
  assign mem_wdata = clearing ? '0 : wb_data;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    if (accept) begin
      rd_a <= store_mem[a_addr_in];
      rd_b <= store_mem[b_addr_in];
    end
  end

  // Stage 1: read data arrives; the product is formed.
  index_t  s1_row, s1_col;
  sample_t s1_y;
  addr_t   s1_a_addr, s1_b_addr;
  logic    s1_a_ok, s1_b_ok;
  logic    s1_a_fwd, s1_b_fwd;
  value_t  s1_a, s1_b;
  logic    hit1_a, hit1_b;
  value_t  a1_eff, b1_eff;
  prod_t   prod_next;

  assign hit1_a = wb_we && s1_a_ok && (wb_addr == s1_a_addr);
  assign hit1_b = wb_we && s1_b_ok && (wb_addr == s1_b_addr);

  always_comb begin
    priority if (!s1_a_ok) a1_eff = '0;
    else if (hit1_a)       a1_eff = wb_data;
    else if (s1_a_fwd)     a1_eff = s1_a;
    else                   a1_eff = rd_a;
    priority if (!s1_b_ok) b1_eff = '0;
    else if (hit1_b)       b1_eff = wb_data;
    else if (s1_b_fwd)     b1_eff = s1_b;
    else                   b1_eff = rd_b;
  end

  assign prod_next = s1_y * $signed({1'b0, step_recip});

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (en1) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_row    <= item.row_index;
      s1_col    <= item.col_index;
      s1_y      <= item.y_sample;
      s1_a_addr <= a_addr_in;
      s1_b_addr <= b_addr_in;
      s1_a_ok   <= a_ok_in;
      s1_b_ok   <= b_ok_in;
      // A write landing on the same edge as the read is not seen by the memory output.
      s1_a_fwd  <= wb_we && (wb_addr == a_addr_in);
      s1_b_fwd  <= wb_we && (wb_addr == b_addr_in);
      s1_a      <= wb_data;
      s1_b      <= wb_data;
    end else begin
      if (hit1_a) begin
        s1_a_fwd <= 1'b1;
        s1_a     <= wb_data;
      end
      if (hit1_b) begin
        s1_b_fwd <= 1'b1;
        s1_b     <= wb_data;
      end
    end
  end

  // Stage 2: product is rounded to Q32.16.
  index_t s2_row, s2_col;
  prod_t  s2_prod;
  addr_t  s2_a_addr, s2_b_addr;
  logic   s2_a_ok, s2_b_ok;
  value_t s2_a, s2_b;
  logic   hit2_a, hit2_b;
  value_t a2_eff, b2_eff;

  assign hit2_a = wb_we && s2_a_ok && (wb_addr == s2_a_addr);
  assign hit2_b = wb_we && s2_b_ok && (wb_addr == s2_b_addr);
  assign a2_eff = hit2_a ? wb_data : s2_a;
  assign b2_eff = hit2_b ? wb_data : s2_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (load2) begin
      s2_valid <= 1'b1;
    end else if (en2) begin
      s2_valid <= 1'b0;
    end
    if (load2) begin
      s2_row    <= s1_row;
      s2_col    <= s1_col;
      s2_prod   <= prod_next;
      s2_a_addr <= s1_a_addr;
      s2_b_addr <= s1_b_addr;
      s2_a_ok   <= s1_a_ok;
      s2_b_ok   <= s1_b_ok;
      s2_a      <= a1_eff;
      s2_b      <= b1_eff;
    end else begin
      s2_a <= a2_eff;
      s2_b <= b2_eff;
    end
  end

  // Stage 3: substitution and store update.
  index_t      s3_row, s3_col;
  value_t      s3_scaled;
  addr_t       s3_a_addr, s3_b_addr;
  logic        s3_a_ok, s3_b_ok;
  value_t      s3_a, s3_b;
  logic        hit3_a, hit3_b;
  value_t      a3_eff, b3_eff;
  wide_value_t diff, sum;
  value_t      z_val, upd_val;

  assign hit3_a  = wb_we && s3_a_ok && (wb_addr == s3_a_addr);
  assign hit3_b  = wb_we && s3_b_ok && (wb_addr == s3_b_addr);
  assign a3_eff  = hit3_a ? wb_data : s3_a;
  assign b3_eff  = hit3_b ? wb_data : s3_b;
  assign diff    = (VALUE_W+1)'(s3_scaled) - (VALUE_W+1)'(a3_eff);
  assign z_val   = sat_value(diff);
  assign sum     = (VALUE_W+1)'(b3_eff) + (VALUE_W+1)'(z_val);
  assign upd_val = sat_value(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (load3) begin
      s3_valid <= 1'b1;
    end else if (en3) begin
      s3_valid <= 1'b0;
    end
    if (load3) begin
      s3_row    <= s2_row;
      s3_col    <= s2_col;
      s3_scaled <= round_product(s2_prod);
      s3_a_addr <= s2_a_addr;
      s3_b_addr <= s2_b_addr;
      s3_a_ok   <= s2_a_ok;
      s3_b_ok   <= s2_b_ok;
      s3_a      <= a2_eff;
      s3_b      <= b2_eff;
    end else begin
      s3_a <= a3_eff;
      s3_b <= b3_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_we <= 1'b0;
    end else begin
      wb_we <= load4 && s3_b_ok;
    end
    wb_addr <= s3_b_addr;
    wb_data <= upd_val;
  end

  // Stage 4: result register, one or two beats per request.
  index_t s4_row, s4_col;
  value_t s4_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
      s4_phase <= 1'b0;
    end else begin
      if (load4) begin
        s4_valid <= 1'b1;
      end else if (s4_done) begin
        s4_valid <= 1'b0;
      end
      if (load4) begin
        s4_phase <= 1'b0;
      end else if (out_fire) begin
        s4_phase <= 1'b1;
      end
    end
    if (load4) begin
      s4_row  <= s3_row;
      s4_col  <= s3_col;
      s4_z    <= z_val;
      s4_diag <= (s3_row == s3_col);
    end
  end

  assign result.valid       = s4_valid;
  assign result.out_row     = s4_phase ? s4_col : s4_row;
  assign result.out_col     = s4_phase ? s4_row : s4_col;
  assign result.entry_value = s4_z;
  assign result.last        = s4_diag || s4_phase;

  // Once the clearing pass ends it never restarts without reset.
  assert property (@(posedge clk) disable iff (rst) !clearing |=> !clearing)
    else $error("store clearing restarted");

  // The mirrored beat only exists for off-diagonal entries.
  assert property (@(posedge clk) disable iff (rst) s4_valid && s4_phase |-> !s4_diag)
    else $error("mirror beat on a diagonal entry");

  // A non-final result is always the first beat of an off-diagonal entry.
  assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.last |-> result.out_row != result.out_col)
    else $error("non-final result on the diagonal");

  // A store update is written exactly once, right after its request entered the result stage.
  assert property (@(posedge clk) disable iff (rst) wb_we |-> $past(load4) && $past(s3_b_ok))
    else $error("store write without a request leaving substitution");

  // No request is taken while the store is being cleared.
  assert property (@(posedge clk) disable iff (rst) s1_valid |-> !clearing)
    else $error("request in flight during store clearing");

endmodule

`default_nettype wire
